>>> hw/rtl/prr_pkg.sv
// Package for the packet reorder reassembler: slot store geometry, entry
// layout, action codes, sequencer states and slot index helper. No dependencies.
`timescale 1ns / 1ps

package prr_pkg;

  // Slot count; a power of two so that the slot index is the low bits of seq.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SEQ_W = 16;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SEQ_W-1:0] seq_t;

  typedef struct packed {
    logic        last;
    logic        first;
    logic [15:0] len;
    logic [15:0] pref;
    seq_t        seq;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_XMIT    = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_WR = 5'b10000
  } state_t;

  function automatic idx_t slot_of(input seq_t s);
    return s[IDX_W-1:0];
  endfunction

  function automatic seq_t seq_add(input seq_t s, input idx_t off);
    return s + {{(SEQ_W-IDX_W){1'b0}}, off};
  endfunction

endpackage

>>> hw/rtl/prr_in_if.sv
// Input channel of the packet reorder reassembler: one packet or clear beat.
// No dependencies.
`timescale 1ns / 1ps

interface prr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        pkt_valid;
  logic [15:0] seq_id;
  logic        is_first_frag;
  logic        is_last_frag;
  logic [15:0] payload_ref;
  logic [15:0] payload_len;

  modport source (
    output valid, action, pkt_valid, seq_id, is_first_frag, is_last_frag,
           payload_ref, payload_len,
    input  ready
  );
  modport sink (
    input  valid, action, pkt_valid, seq_id, is_first_frag, is_last_frag,
           payload_ref, payload_len,
    output ready
  );
endinterface

>>> hw/rtl/prr_out_if.sv
// Output channel of the packet reorder reassembler: one fragment beat.
// No dependencies.
`timescale 1ns / 1ps

interface prr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_ref;
  logic [15:0] out_len;
  logic        frame_end;
  logic        run_last;

  modport source (
    output valid, out_ref, out_len, frame_end, run_last,
    input  ready
  );
  modport sink (
    input  valid, out_ref, out_len, frame_end, run_last,
    output ready
  );
endinterface

>>> hw/rtl/packet_reorder_reassembler.sv
// Packet reorder buffer with frame reassembly by handle.
// Push: accept, then a scan of up to DEPTH-1 slots (one slot read per cycle through the
// single memory read port, pipelined with the check), then ST_XMIT for a pass-through
// fragment, ST_EMIT_RD then ST_EMIT_WR per stored fragment emitted and ST_EMIT_RD per
// skipped position, plus output stalls; input is not ready until the item ends.
// Clear and dropped packets stay idle. Sync reset clears head, seen flag, valid bits.
`timescale 1ns / 1ps

module packet_reorder_reassembler
  import prr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  prr_in_if.sink    pkt,
  prr_out_if.source frag
);

  state_t           state;
  seq_t             head_seq;
  logic             seen_any;
  logic [DEPTH-1:0] slot_valid;
  entry_t           slot_mem [DEPTH];

  // per-item work registers
  logic             xmit_pend;
  logic [15:0]      item_ref;
  logic [15:0]      item_len;
  idx_t             scan_i;
  idx_t             eval_i;
  logic             eval_vld;
  entry_t           rd_entry;
  logic             rd_valid;
  logic             run_open;
  idx_t             run_start;
  idx_t             adv;
  logic [DEPTH-1:0] emit_mask;
  logic [DEPTH-1:0] end_mask;
  idx_t             emit_k;

  // output register
  logic             out_valid;
  logic [15:0]      out_ref;
  logic [15:0]      out_len;
  logic             out_end;
  logic             out_last;

  logic   accept;
  logic   is_push;
  logic   transit;
  logic   far;
  seq_t   fwd_dist;
  seq_t   bwd_dist;
  logic   mem_we;
  logic   mem_re;
  idx_t   rd_idx;
  logic   out_free;
  logic   issue;
  logic   hit;
  logic   open_n;
  idx_t   start_n;
  logic   close;
  logic   scan_done;
  idx_t   adv_next;
  logic   out_load;
  logic   load_last;
  entry_t wr_entry;

  assign pkt.ready  = (state == ST_IDLE);
  assign accept     = pkt.valid && pkt.ready;
  assign is_push    = accept && (pkt.action == ACT_PUSH) && pkt.pkt_valid;
  assign transit    = (!seen_any || pkt.seq_id == head_seq) &&
                      pkt.is_first_frag && pkt.is_last_frag;
  assign fwd_dist   = pkt.seq_id - head_seq;
  assign bwd_dist   = head_seq - pkt.seq_id;
  assign far        = (fwd_dist > SEQ_W'(DEPTH)) && (bwd_dist > SEQ_W'(DEPTH));
  assign mem_we     = is_push && !transit;
  assign wr_entry   = '{last: pkt.is_last_frag, first: pkt.is_first_frag,
                        len: pkt.payload_len, pref: pkt.payload_ref, seq: pkt.seq_id};

  assign out_free   = !out_valid || frag.ready;
  assign issue      = (state == ST_SCAN) && (scan_i != idx_t'(DEPTH - 1));
  assign rd_idx     = slot_of(seq_add(head_seq, (state == ST_EMIT_RD) ? emit_k : scan_i));
  assign mem_re     = issue || ((state == ST_EMIT_RD) && emit_mask[emit_k]);

  // scan check of the slot read in the previous cycle
  assign hit        = eval_vld && rd_valid && (rd_entry.seq == seq_add(head_seq, eval_i));
  assign open_n     = run_open || rd_entry.first;
  assign start_n    = rd_entry.first ? eval_i : run_start;
  assign close      = hit && open_n && rd_entry.last;
  assign adv_next   = close ? eval_i + idx_t'(1) : adv;
  assign scan_done  = eval_vld && (!hit || eval_i == idx_t'(DEPTH - 2));

  assign out_load   = ((state == ST_XMIT) || (state == ST_EMIT_WR)) && out_free;
  assign load_last  = (state == ST_XMIT) ? (adv == '0) : (emit_k == adv - idx_t'(1));

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[slot_of(pkt.seq_id)] <= wr_entry;
    if (mem_re) rd_entry <= slot_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_seq   <= '0;
      seen_any   <= 1'b0;
      slot_valid <= '0;
      xmit_pend  <= 1'b0;
      scan_i     <= '0;
      eval_i     <= '0;
      eval_vld   <= 1'b0;
      rd_valid   <= 1'b0;
      run_open   <= 1'b0;
      run_start  <= '0;
      adv        <= '0;
      emit_mask  <= '0;
      end_mask   <= '0;
      emit_k     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (pkt.action == ACT_CLEAR)) begin
            slot_valid <= '0;
            seen_any   <= 1'b0;
          end else if (is_push) begin
            seen_any  <= 1'b1;
            xmit_pend <= transit;
            if (transit) begin
              head_seq <= pkt.seq_id + SEQ_W'(1);
            end else begin
              slot_valid[slot_of(pkt.seq_id)] <= 1'b1;
              if (!seen_any) head_seq <= pkt.seq_id;
              else if (far)  head_seq <= pkt.seq_id - SEQ_W'(DEPTH - 1);
            end
            scan_i    <= '0;
            eval_vld  <= 1'b0;
            run_open  <= 1'b0;
            run_start <= '0;
            adv       <= '0;
            emit_mask <= '0;
            end_mask  <= '0;
            emit_k    <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          eval_vld <= issue;
          if (issue) begin
            rd_valid <= slot_valid[rd_idx];
            eval_i   <= scan_i;
            scan_i   <= scan_i + idx_t'(1);
          end
          if (hit) begin
            run_open  <= open_n && !rd_entry.last;
            run_start <= start_n;
          end
          if (close) begin
            for (int k = 0; k < DEPTH; k++) begin
              if (idx_t'(k) >= start_n && idx_t'(k) <= eval_i) emit_mask[k] <= 1'b1;
            end
            end_mask[eval_i] <= 1'b1;
            adv              <= adv_next;
          end
          if (scan_done) begin
            if (xmit_pend)           state <= ST_XMIT;
            else if (adv_next != '0) state <= ST_EMIT_RD;
            else                     state <= ST_IDLE;
          end
        end
        ST_XMIT: begin
          if (out_free) state <= (adv != '0) ? ST_EMIT_RD : ST_IDLE;
        end
        ST_EMIT_RD: begin
          // positions skipped by a broken run are stepped over
          if (emit_mask[emit_k]) state  <= ST_EMIT_WR;
          else                   emit_k <= emit_k + idx_t'(1);
        end
        ST_EMIT_WR: begin
          if (out_free) begin
            slot_valid[slot_of(seq_add(head_seq, emit_k))] <= 1'b0;
            if (load_last) begin
              head_seq <= seq_add(head_seq, adv);
              state    <= ST_IDLE;
            end else begin
              emit_k <= emit_k + idx_t'(1);
              state  <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // transit fields latched at accept
  always_ff @(posedge clk) begin
    if (is_push) begin
      item_ref <= pkt.payload_ref;
      item_len <= pkt.payload_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (frag.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_last <= load_last;
      if (state == ST_XMIT) begin
        out_ref <= item_ref;
        out_len <= item_len;
        out_end <= 1'b1;
      end else begin
        out_ref <= rd_entry.pref;
        out_len <= rd_entry.len;
        out_end <= end_mask[emit_k];
      end
    end
  end

  assign frag.valid     = out_valid;
  assign frag.out_ref   = out_ref;
  assign frag.out_len   = out_len;
  assign frag.frame_end = out_end;
  assign frag.run_last  = out_last;

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (pkt.action == ACT_CLEAR) |=> slot_valid == '0)
    else $error("clear left a slot valid");

  a_emit_has_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_RD |-> adv != '0 && emit_mask[adv - idx_t'(1)])
    else $error("emit phase without a closed run");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && load_last |=> state == ST_IDLE && frag.valid && frag.run_last)
    else $error("final beat did not end the item");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    eval_vld |-> eval_i <= idx_t'(DEPTH - 2))
    else $error("scan ran past DEPTH-1 slots");

  a_emit_slot_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_WR |-> slot_valid[slot_of(seq_add(head_seq, emit_k))])
    else $error("emitting a slot that is not valid");

endmodule

>>> test/tb_packet_reorder_reassembler.sv
// Testbench for packet_reorder_reassembler: directed and random fragment traffic,
// checked against a cycle-free reassembly predictor. Needs prr_pkg, prr_in_if,
// prr_out_if and the block itself.
`timescale 1ns / 1ps

module tb_packet_reorder_reassembler
  import prr_pkg::*;
();

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 100;
  localparam int RANDOM_PUSHES  = 80;
  localparam int CALM_PUSHES    = 30;

  typedef struct packed {
    logic        action;
    logic        pkt_valid;
    logic [15:0] seq;
    logic        first;
    logic        last;
    logic [15:0] handle;
    logic [15:0] len;
  } pkt_beat_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] len;
    logic        fend;
    logic        rlast;
  } frag_beat_t;

  logic clk;
  logic rst;

  prr_in_if  pkt_if ();
  prr_out_if frag_if ();

  packet_reorder_reassembler dut (
    .clk  (clk),
    .rst  (rst),
    .pkt  (pkt_if),
    .frag (frag_if)
  );

  // Predictor state
  logic [15:0] exp_head;
  bit          exp_seen;
  bit          exp_slot_valid [DEPTH];
  entry_t      exp_slot [DEPTH];
  frag_beat_t  pending_frags [$];

  int          errors;
  int          pushes_sent;
  int          quiet_cycles;
  bit          tx_gaps;
  bit          rx_gaps;
  bit          hold_req;
  logic [15:0] seq_cursor;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the fragments one accepted beat releases and queues them.
  task automatic reassemble_beat(input pkt_beat_t b);
    frag_beat_t  emitted [$];
    frag_beat_t  fb;
    logic [15:0] pos;
    logic [15:0] fwd;
    logic [15:0] bwd;
    int          i;
    int          k;
    int          ix;
    int          run_start;
    int          advance;
    bit          fresh;
    bit          open;
    if (b.action == ACT_CLEAR) begin
      for (i = 0; i < DEPTH; i++) exp_slot_valid[i] = 1'b0;
      exp_seen = 1'b0;
      return;
    end
    if (!b.pkt_valid) return;
    fresh = !exp_seen;
    exp_seen = 1'b1;
    if ((fresh || b.seq == exp_head) && b.first && b.last) begin
      exp_head = b.seq + 16'd1;
      fb = '{b.handle, b.len, 1'b1, 1'b0};
      emitted = {emitted, fb};
    end else begin
      fwd = b.seq - exp_head;
      bwd = exp_head - b.seq;
      if (fresh) begin
        exp_head = b.seq;
      end else if (fwd > 16'(DEPTH) && bwd > 16'(DEPTH)) begin
        exp_head = b.seq - 16'(DEPTH - 1);
      end
      ix = b.seq % DEPTH;
      exp_slot[ix] = '{b.last, b.first, b.len, b.handle, b.seq};
      exp_slot_valid[ix] = 1'b1;
    end
    open = 1'b0;
    run_start = 0;
    advance = 0;
    for (i = 0; i < DEPTH - 1; i++) begin
      pos = exp_head + i[15:0];
      ix = pos % DEPTH;
      if (!exp_slot_valid[ix] || exp_slot[ix].seq != pos) break;
      // a first flag inside an open run drops what came before it
      if (exp_slot[ix].first) begin
        open = 1'b1;
        run_start = i;
      end
      if (open && exp_slot[ix].last) begin
        for (k = run_start; k <= i; k++) begin
          pos = exp_head + k[15:0];
          ix = pos % DEPTH;
          fb = '{exp_slot[ix].pref, exp_slot[ix].len, k == i, 1'b0};
          emitted = {emitted, fb};
          exp_slot_valid[ix] = 1'b0;
        end
        advance = i + 1;
        open = 1'b0;
      end
    end
    exp_head = exp_head + advance[15:0];
    if (emitted.size() > 0) emitted[emitted.size() - 1].rlast = 1'b1;
    pending_frags = {pending_frags, emitted};
  endtask

  function automatic pkt_beat_t push_beat(input logic [15:0] seq, input bit first,
                                          input bit last);
    pkt_beat_t b;
    b.action    = ACT_PUSH;
    b.pkt_valid = 1'b1;
    b.seq       = seq;
    b.first     = first;
    b.last      = last;
    b.handle    = 16'($urandom);
    b.len       = 16'($urandom);
    return b;
  endfunction

  function automatic pkt_beat_t clear_beat();
    pkt_beat_t b;
    b = push_beat(16'($urandom), 1'($urandom), 1'($urandom));
    b.pkt_valid = 1'($urandom);
    b.action    = ACT_CLEAR;
    return b;
  endfunction

  // Off-sequence or malformed packet, near the cursor or anywhere.
  function automatic pkt_beat_t noise_beat();
    pkt_beat_t b;
    b = push_beat(16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) b.seq = 16'(seq_cursor + $urandom_range(0, 40) - 20);
    b.pkt_valid = $urandom_range(0, 2) != 0;
    return b;
  endfunction

  // Called just after a falling edge. Leaves valid high on return unless it inserts a gap.
  task automatic send_beat(input pkt_beat_t b);
    pkt_if.valid         = 1'b1;
    pkt_if.action        = b.action;
    pkt_if.pkt_valid     = b.pkt_valid;
    pkt_if.seq_id        = b.seq;
    pkt_if.is_first_frag = b.first;
    pkt_if.is_last_frag  = b.last;
    pkt_if.payload_ref   = b.handle;
    pkt_if.payload_len   = b.len;
    @(posedge clk);
    while (!pkt_if.ready) @(posedge clk);
    reassemble_beat(b);
    if (b.action == ACT_PUSH && b.pkt_valid) pushes_sent++;
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      pkt_if.valid         = 1'b0;
      pkt_if.seq_id        = 16'($urandom);
      pkt_if.payload_ref   = 16'($urandom);
      pkt_if.payload_len   = 16'($urandom);
      pkt_if.is_first_frag = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    pkt_if.valid = 1'b0;
    while (pending_frags.size() != 0) @(negedge clk);
  endtask

  // First packet ever passes straight through, then a complete one at the head;
  // field extremes and a dropped packet.
  task automatic test_passthrough();
    pkt_beat_t b;
    b = push_beat(16'hFFFF, 1'b1, 1'b1);
    b.handle = 16'hFFFF;
    b.len    = 16'h0000;
    send_beat(b);
    b = push_beat(16'h0000, 1'b1, 1'b1);
    b.handle = 16'h0000;
    b.len    = 16'hFFFF;
    send_beat(b);
    b = push_beat(16'h0001, 1'b1, 1'b1);
    b.pkt_valid = 1'b0;
    send_beat(b);
  endtask

  task automatic test_out_of_order();
    send_beat(push_beat(16'h0003, 1'b0, 1'b1));
    send_beat(push_beat(16'h0002, 1'b0, 1'b0));
    send_beat(push_beat(16'h0001, 1'b1, 1'b0));
  endtask

  // Second first flag restarts the run; the orphan stays in its slot.
  task automatic test_broken_run();
    send_beat(push_beat(16'h0006, 1'b0, 1'b1));
    send_beat(push_beat(16'h0005, 1'b1, 1'b0));
    send_beat(push_beat(16'h0004, 1'b1, 1'b0));
  endtask

  // Head jump on a far packet, overwrite of an orphan, a stale slot stopping the scan.
  task automatic test_far_and_stale();
    send_beat(push_beat(16'h8000, 1'b1, 1'b0));
    send_beat(push_beat(16'h7FF1, 1'b1, 1'b1));
    send_beat(push_beat(16'h7FF4, 1'b1, 1'b1));
    send_beat(push_beat(16'h7FF3, 1'b1, 1'b1));
    send_beat(push_beat(16'h7FF2, 1'b0, 1'b0));
    send_beat(push_beat(16'h7FF6, 1'b1, 1'b1));
    send_beat(push_beat(16'h8005, 1'b0, 1'b1));
    send_beat(push_beat(16'h7FF5, 1'b1, 1'b1));
  endtask

  task automatic test_clear();
    send_beat(push_beat(16'h1234, 1'b1, 1'b0));
    send_beat(clear_beat());
    send_beat(push_beat(16'h4321, 1'b0, 1'b1));
    send_beat(clear_beat());
    send_beat(push_beat(16'hABCD, 1'b1, 1'b1));
  endtask

  // Output held off while a scan-window frame and more packets arrive, so the
  // block backs up into its input; then a pause until all fragments are out.
  task automatic test_backpressure();
    logic [15:0] h;
    int          i;
    drain_results();
    h = 16'($urandom);
    hold_req = 1'b1;
    send_beat(clear_beat());
    send_beat(push_beat(h, 1'b1, 1'b0));
    send_beat(push_beat(h + 16'd15, 1'b0, 1'b1));
    for (i = 14; i >= 2; i--) send_beat(push_beat(h + i[15:0], 1'b0, 1'b0));
    send_beat(push_beat(h + 16'd1, 1'b1, 1'b0));
    // transit plus the whole scan window: the largest burst one beat can cause
    send_beat(push_beat(h, 1'b1, 1'b1));
    for (i = 16; i < 20; i++) send_beat(push_beat(h + i[15:0], 1'b1, 1'b1));
    drain_results();
    seq_cursor = h + 16'd20;
  endtask

  // A window of whole frames at the cursor, usually shuffled, with the odd lost or
  // repeated fragment and some noise mixed in.
  task automatic send_window();
    pkt_beat_t win [$];
    pkt_beat_t tmp;
    int        target;
    int        span;
    int        flen;
    int        j;
    int        r;
    target = $urandom_range(1, DEPTH - 1);
    span = 0;
    while (span < target) begin
      flen = $urandom_range(1, 4);
      if (flen > target - span) flen = target - span;
      for (j = 0; j < flen; j++) begin
        tmp = push_beat(seq_cursor, j == 0, j == flen - 1);
        seq_cursor++;
        r = $urandom_range(0, 39);
        if (r != 0) win = {win, tmp};
        if (r == 1) win = {win, tmp};
      end
      span += flen;
    end
    if ($urandom_range(0, 3) != 0) begin
      for (j = win.size() - 1; j > 0; j--) begin
        r = $urandom_range(0, j);
        tmp = win[j];
        win[j] = win[r];
        win[r] = tmp;
      end
    end
    foreach (win[i]) begin
      if ($urandom_range(0, 11) == 0) send_beat(noise_beat());
      send_beat(win[i]);
    end
  endtask

  task automatic test_random_traffic();
    int goal;
    goal = pushes_sent + RANDOM_PUSHES;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    while (pushes_sent < goal) begin
      if (pushes_sent >= goal - CALM_PUSHES) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      case ($urandom_range(0, 19))
        0: send_beat(clear_beat());
        1: if (tx_gaps) drain_results();
        2: seq_cursor = 16'(seq_cursor + $urandom_range(DEPTH + 1, 40000));
        default: send_window();
      endcase
    end
  endtask

  initial begin : frag_sink
    frag_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        frag_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        frag_if.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      frag_if.ready = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_frags
    frag_beat_t want;
    if (!rst && frag_if.valid && frag_if.ready) begin
      if (pending_frags.size() == 0) begin
        errors++;
        $display("%0t: unexpected fragment: expected none, got ref %h len %h end %b last %b",
                 $time, frag_if.out_ref, frag_if.out_len, frag_if.frame_end,
                 frag_if.run_last);
      end else begin
        want = pending_frags.pop_front();
        if (frag_if.out_ref !== want.handle || frag_if.out_len !== want.len ||
            frag_if.frame_end !== want.fend || frag_if.run_last !== want.rlast) begin
          errors++;
          $display("%0t: fragment mismatch: expected ref %h len %h end %b last %b, got ref %h len %h end %b last %b",
                   $time, want.handle, want.len, want.fend, want.rlast,
                   frag_if.out_ref, frag_if.out_len, frag_if.frame_end, frag_if.run_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pkt_if.valid && pkt_if.ready) || (frag_if.valid && frag_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d fragments outstanding",
               $time, WATCHDOG_LIMIT, pending_frags.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    exp_head     = 16'h0000;
    exp_seen     = 1'b0;
    for (i = 0; i < DEPTH; i++) begin
      exp_slot_valid[i] = 1'b0;
      exp_slot[i]       = '0;
    end
    errors       = 0;
    pushes_sent  = 0;
    quiet_cycles = 0;
    tx_gaps      = 1'b0;
    rx_gaps      = 1'b0;
    hold_req     = 1'b0;
    seq_cursor   = 16'($urandom);

    pkt_if.valid         = 1'b0;
    pkt_if.action        = ACT_PUSH;
    pkt_if.pkt_valid     = 1'b0;
    pkt_if.seq_id        = '0;
    pkt_if.is_first_frag = 1'b0;
    pkt_if.is_last_frag  = 1'b0;
    pkt_if.payload_ref   = '0;
    pkt_if.payload_len   = '0;

    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_passthrough();
    test_out_of_order();
    test_broken_run();
    test_far_and_stale();
    test_clear();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/prr_pkg.sv
hw/rtl/prr_in_if.sv
hw/rtl/prr_out_if.sv
hw/rtl/packet_reorder_reassembler.sv
test/tb_packet_reorder_reassembler.sv
